@@ rtl/wpf_pkg.sv @@
package wpf_pkg;

  localparam int DATA_W   = 8;
  localparam int COORD_W  = 8;
  localparam int CANVAS_W = 9;
  localparam int LEN_W    = 64;
  localparam int KEY_W    = 32;
  localparam int OPC_W    = 4;
  localparam int POS_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = CANVAS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RST  = 9'd100;
  localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RST = 9'd100;

  localparam logic [OPC_W-1:0] OPC_BINARY = 4'h2;
  localparam logic [OPC_W-1:0] OPC_CLOSE  = 4'h8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [POS_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [POS_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [POS_W-1:0] KEY_BYTES   = 4'd4;

  localparam logic EV_PIXEL = 1'b0;
  localparam logic EV_CLOSE = 1'b1;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    SLOT_X     = 2'd0,
    SLOT_Y     = 2'd1,
    SLOT_COLOR = 2'd2
  } slot_t;

endpackage

@@ rtl/wpf_if.sv @@
interface wpf_in_if import wpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface wpf_out_if import wpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               event_kind;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [DATA_W-1:0]  pixel_color;

  modport source (output valid, output event_kind, output pixel_x, output pixel_y,
                  output pixel_color, input ready);
  modport sink   (input valid, input event_kind, input pixel_x, input pixel_y,
                  input pixel_color, output ready);
endinterface

@@ rtl/websocket_pixel_frame_parser_core.sv @@
// A result is registered: it is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the per-byte path is the 64-bit remaining-length
// decrement and compare, between the parser state and the result register.
// A held result does not stall input unless the result register is full and not taken.
// Reset (rst_n low, synchronous): parser back to the first header byte, no result
// pending, canvas width and height back to 100.
module websocket_pixel_frame_parser_core import wpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wpf_in_if.sink                in_chan,
  wpf_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CANVAS_W-1:0] canvas_w_r, canvas_h_r;

  phase_t              phase_r, phase_nxt;
  logic [OPC_W-1:0]    opcode_r, opcode_nxt;
  logic                mask_r, mask_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;     // length while parsing, bytes left in payload
  logic [1:0]          idx_r, idx_nxt;     // payload index mod 4
  logic [KEY_W-1:0]    key_r, key_nxt;
  slot_t               slot_r, slot_nxt;
  logic [COORD_W-1:0]  held_x_r, held_x_nxt, held_y_r, held_y_nxt;

  logic                out_valid_r;
  logic                out_kind_r;
  logic [COORD_W-1:0]  out_x_r, out_y_r;
  logic [DATA_W-1:0]   out_color_r;

  logic                ev_valid, ev_kind;
  logic [COORD_W-1:0]  ev_x, ev_y;
  logic [DATA_W-1:0]   ev_color;

  logic [DATA_W-1:0]   b, v, key_byte;
  logic [LEN_W-1:0]    len_cand;
  logic                len_done, hdr_done, in_fire, in_rdy;

  assign b       = in_chan.data_byte;
  assign in_rdy  = !out_valid_r || out_chan.ready;
  assign in_fire = in_chan.valid && in_rdy;
  assign in_chan.ready = in_rdy;

  always_comb begin
    unique case (idx_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign v = mask_r ? (b ^ key_byte) : b;

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    slot_nxt   = slot_r;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    ev_valid   = 1'b0;
    ev_kind    = EV_PIXEL;
    ev_x       = '0;
    ev_y       = '0;
    ev_color   = '0;
    len_cand   = len_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;

    unique case (phase_r)
      PH_HDR1: begin
        mask_nxt = b[7];
        key_nxt  = '0;
        if (b[6:0] == LEN7_EXT16) begin
          len_nxt   = '0;
          pos_nxt   = EXT16_BYTES;
          phase_nxt = PH_EXTLEN;
        end else if (b[6:0] == LEN7_EXT64) begin
          len_nxt   = '0;
          pos_nxt   = EXT64_BYTES;
          phase_nxt = PH_EXTLEN;
        end else begin
          len_cand = {{(LEN_W-7){1'b0}}, b[6:0]};
          len_nxt  = len_cand;
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_cand = {len_r[LEN_W-DATA_W-1:0], b};
        len_nxt  = len_cand;
        pos_nxt  = pos_r - POS_W'(1);
        len_done = (pos_r == 4'd1);
      end
      PH_KEY: begin
        key_nxt  = {key_r[KEY_W-DATA_W-1:0], b};
        pos_nxt  = pos_r - POS_W'(1);
        hdr_done = (pos_r == 4'd1);
      end
      PH_PAYLOAD: begin
        if (opcode_r == OPC_BINARY) begin
          unique case (slot_r)
            SLOT_X: begin
              held_x_nxt = v;
              slot_nxt   = SLOT_Y;
            end
            SLOT_Y: begin
              held_y_nxt = v;
              slot_nxt   = SLOT_COLOR;
            end
            default: begin
              if ({1'b0, held_x_r} < canvas_w_r && {1'b0, held_y_r} < canvas_h_r) begin
                ev_valid = 1'b1;
                ev_kind  = EV_PIXEL;
                ev_x     = held_x_r;
                ev_y     = held_y_r;
                ev_color = v;
              end
              slot_nxt = SLOT_X;
            end
          endcase
        end
        idx_nxt = idx_r + 2'd1;
        len_nxt = len_r - LEN_W'(1);
        if (len_r == {{(LEN_W-1){1'b0}}, 1'b1}) begin
          phase_nxt = PH_HDR0;
          slot_nxt  = SLOT_X;
          idx_nxt   = '0;
          if (opcode_r == OPC_CLOSE) begin
            ev_valid = 1'b1;
            ev_kind  = EV_CLOSE;
          end
        end
      end
      default: begin
        opcode_nxt = b[OPC_W-1:0];
        phase_nxt  = PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (mask_nxt) begin
        phase_nxt = PH_KEY;
        pos_nxt   = KEY_BYTES;
        key_nxt   = '0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header complete: enter payload, or finish an empty frame here
    if (hdr_done) begin
      idx_nxt  = '0;
      slot_nxt = SLOT_X;
      pos_nxt  = '0;
      if (len_cand != '0) begin
        phase_nxt = PH_PAYLOAD;
      end else begin
        phase_nxt = PH_HDR0;
        if (opcode_r == OPC_CLOSE) begin
          ev_valid = 1'b1;
          ev_kind  = EV_CLOSE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= CANVAS_WIDTH_RST;
      canvas_h_r <= CANVAS_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CANVAS_WIDTH: canvas_w_r <= cfg_wdata;
        default:          canvas_h_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      pos_r    <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      key_r    <= '0;
      slot_r   <= SLOT_X;
      held_x_r <= '0;
      held_y_r <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      key_r    <= key_nxt;
      slot_r   <= slot_nxt;
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
    end
  end

  // result register: load on a producing beat, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_rdy) begin
      out_valid_r <= in_fire && ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && ev_valid) begin
      out_kind_r  <= ev_kind;
      out_x_r     <= ev_x;
      out_y_r     <= ev_y;
      out_color_r <= ev_color;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.event_kind  = out_kind_r;
  assign out_chan.pixel_x     = out_x_r;
  assign out_chan.pixel_y     = out_y_r;
  assign out_chan.pixel_color = out_color_r;

endmodule

@@ dv/wpf_frame_checker.sv @@
`timescale 1ns / 100ps

module wpf_frame_checker import wpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wpf_in_if                     in_mon,
  wpf_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  test_done,
  output int                    mismatches,
  output int                    pending_events,
  output int                    pixels_checked,
  output int                    closes_checked
);

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DATA_W-1:0]  color;
  } pix_event_t;

  pix_event_t expected_events[$];

  int err_cnt   = 0;
  int pend_cnt  = 0;
  int pix_cnt   = 0;
  int close_cnt = 0;

  assign mismatches     = err_cnt;
  assign pending_events = pend_cnt;
  assign pixels_checked = pix_cnt;
  assign closes_checked = close_cnt;

  // Parser mirror and canvas registers
  logic [CANVAS_W-1:0] cw, ch;
  phase_t              ph;
  logic [OPC_W-1:0]    opc;
  logic                msk;
  logic [POS_W-1:0]    pos;
  logic [LEN_W-1:0]    plen, pidx;
  logic [KEY_W-1:0]    key;
  slot_t               slot;
  logic [COORD_W-1:0]  hx, hy;

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic reset_parser();
    cw   = CANVAS_WIDTH_RST;
    ch   = CANVAS_HEIGHT_RST;
    ph   = PH_HDR0;
    opc  = '0;
    msk  = 1'b0;
    pos  = '0;
    plen = '0;
    pidx = '0;
    key  = '0;
    slot = SLOT_X;
    hx   = '0;
    hy   = '0;
  endtask

  task automatic push_event(input logic kind, input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] c);
    expected_events.push_back('{kind: kind, x: x, y: y, color: c});
  endtask

  task automatic header_done();
    pidx = '0;
    slot = SLOT_X;
    pos  = '0;
    if (plen != '0) begin
      ph = PH_PAYLOAD;
    end else begin
      ph = PH_HDR0;
      if (opc == OPC_CLOSE) push_event(EV_CLOSE, 8'd0, 8'd0, 8'd0);
    end
  endtask

  task automatic length_done();
    if (msk) begin
      ph  = PH_KEY;
      pos = KEY_BYTES;
      key = '0;
    end else begin
      header_done();
    end
  endtask

  task automatic parse_byte(input logic [DATA_W-1:0] b);
    logic [7:0] v;
    logic [1:0] sel;
    case (ph)
      PH_HDR1: begin
        msk = b[7];
        key = '0;
        if (b[6:0] == LEN7_EXT16) begin
          plen = '0;
          pos  = EXT16_BYTES;
          ph   = PH_EXTLEN;
        end else if (b[6:0] == LEN7_EXT64) begin
          plen = '0;
          pos  = EXT64_BYTES;
          ph   = PH_EXTLEN;
        end else begin
          plen = LEN_W'(b[6:0]);
          length_done();
        end
      end
      PH_EXTLEN: begin
        plen = {plen[LEN_W-9:0], b};
        pos  = pos - POS_W'(1);
        if (pos == '0) length_done();
      end
      PH_KEY: begin
        key = {key[KEY_W-9:0], b};
        pos = pos - POS_W'(1);
        if (pos == '0) header_done();
      end
      PH_PAYLOAD: begin
        v   = b;
        sel = pidx[1:0];
        if (msk) v = b ^ key[8*(3 - int'(sel)) +: 8];
        if (opc == OPC_BINARY) begin
          case (slot)
            SLOT_X: begin
              hx   = v;
              slot = SLOT_Y;
            end
            SLOT_Y: begin
              hy   = v;
              slot = SLOT_COLOR;
            end
            default: begin
              if ({1'b0, hx} < cw && {1'b0, hy} < ch) push_event(EV_PIXEL, hx, hy, v);
              slot = SLOT_X;
            end
          endcase
        end
        pidx = pidx + LEN_W'(1);
        if (pidx == plen) begin
          // drop any partial triplet at the frame end
          ph   = PH_HDR0;
          slot = SLOT_X;
          pidx = '0;
          if (opc == OPC_CLOSE) push_event(EV_CLOSE, 8'd0, 8'd0, 8'd0);
        end
      end
      default: begin
        opc = b[OPC_W-1:0];
        ph  = PH_HDR1;
      end
    endcase
  endtask

  task automatic check_event();
    pix_event_t got, want;
    got = '{kind: out_mon.event_kind, x: out_mon.pixel_x, y: out_mon.pixel_y,
            color: out_mon.pixel_color};
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected: kind %0d x %0d y %0d c %0d",
                                got.kind, got.x, got.y, got.color));
    end else begin
      want = expected_events.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("event_kind got %0d expected %0d", got.kind, want.kind));
      if (got.x !== want.x)
        report_mismatch($sformatf("pixel_x got %0d expected %0d", got.x, want.x));
      if (got.y !== want.y)
        report_mismatch($sformatf("pixel_y got %0d expected %0d", got.y, want.y));
      if (got.color !== want.color)
        report_mismatch($sformatf("pixel_color got %0d expected %0d", got.color, want.color));
      if (want.kind == EV_CLOSE) close_cnt++;
      else pix_cnt++;
    end
  endtask

  initial reset_parser();

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_parser();
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CANVAS_WIDTH:  cw = cfg_wdata;
          CFG_CANVAS_HEIGHT: ch = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.data_byte);
      if (out_mon.valid && out_mon.ready) check_event();
    end
    pend_cnt <= expected_events.size();
  end

  always @(posedge test_done) begin
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected events never arrived", expected_events.size()));
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import wpf_pkg::*;

  localparam int BYTES_PER_PHASE = 220;
  localparam int NUM_PHASES      = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_LIMIT     = 500;
  localparam int SETTLE_CYCLES   = 4;
  localparam logic [7:0] FIN_BIT = 8'h80;

  typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_CANVAS_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  rsp_ready = 1'b0;
  logic                  test_done = 1'b0;

  bit  gaps_on     = 1'b1;
  int  gap_odds    = 0;
  int  stall_odds  = 0;
  int  stall_left  = 0;
  int  idle_cycles = 0;
  int  bytes_sent  = 0;
  int  frames_sent = 0;

  logic [CANVAS_W-1:0] cur_w = CANVAS_WIDTH_RST;
  logic [CANVAS_W-1:0] cur_h = CANVAS_HEIGHT_RST;
  logic [CANVAS_W-1:0] w_plan [NUM_PHASES];
  logic [CANVAS_W-1:0] h_plan [NUM_PHASES];
  logic [7:0]          body_q [$];

  int mismatches, pending_events, pixels_checked, closes_checked;

  wpf_in_if  in_chan ();
  wpf_out_if out_chan ();

  assign out_chan.ready = rsp_ready;

  websocket_pixel_frame_parser_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  wpf_frame_checker frame_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .test_done     (test_done),
    .mismatches    (mismatches),
    .pending_events(pending_events),
    .pixels_checked(pixels_checked),
    .closes_checked(closes_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else if (gaps_on && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left <= $urandom_range(0, 13);
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat in %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] pick_coord(input logic [CANVAS_W-1:0] lim);
    int hi;
    hi = (lim == 0 || lim > 256) ? 255 : int'(lim) - 1;
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'(hi);
      2:       return (lim > 255) ? 8'd255 : lim[7:0];
      default: return 8'($urandom_range(0, hi));
    endcase
  endfunction

  // Present one beat, optionally after an input gap, and hold until taken
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
  endtask

  // Frame body comes unmasked from body_q; decl_len may differ from its size
  task automatic send_frame(input logic [7:0] h1, input logic masked, input len_form_t form,
                            input logic [LEN_W-1:0] decl_len);
    logic [KEY_W-1:0] key;
    logic [6:0]       len7;
    int               i;
    key = $urandom;
    case (form)
      LEN_EXT16: len7 = LEN7_EXT16;
      LEN_EXT64: len7 = LEN7_EXT64;
      default:   len7 = decl_len[6:0];
    endcase
    send_byte(h1);
    send_byte({masked, len7});
    if (form == LEN_EXT16) begin
      send_byte(decl_len[15:8]);
      send_byte(decl_len[7:0]);
    end else if (form == LEN_EXT64) begin
      for (i = 7; i >= 0; i--) send_byte(decl_len[8*i +: 8]);
    end
    if (masked) for (i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (i = 0; i < body_q.size(); i++)
      send_byte(body_q[i] ^ (masked ? key[8*(3 - (i % 4)) +: 8] : 8'h00));
    frames_sent++;
  endtask

  task automatic push_triplets(input int n);
    repeat (n) begin
      body_q.push_back(pick_coord(cur_w));
      body_q.push_back(pick_coord(cur_h));
      body_q.push_back(8'($urandom));
    end
  endtask

  task automatic random_frame();
    int         r;
    logic [3:0] opc;
    logic       masked;
    len_form_t  form;
    r = $urandom_range(0, 99);
    body_q.delete();
    gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
    stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
    if (r < 70) begin
      opc = OPC_BINARY;
      push_triplets(($urandom_range(0, 9) == 0) ? $urandom_range(13, 45) : $urandom_range(0, 8));
      // leave a partial triplet now and then
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) body_q.push_back(8'($urandom));
    end else if (r < 82) begin
      opc = OPC_CLOSE;
      if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom));
    end else begin
      do opc = 4'($urandom); while (opc == OPC_BINARY || opc == OPC_CLOSE);
      repeat ($urandom_range(0, 24)) body_q.push_back(8'($urandom));
    end
    masked = 1'($urandom);
    if (body_q.size() > 125) begin
      form = ($urandom_range(0, 1) == 1) ? LEN_EXT16 : LEN_EXT64;
    end else begin
      case ($urandom_range(0, 6))
        0:       form = LEN_EXT16;
        1:       form = LEN_EXT64;
        default: form = LEN_SHORT;
      endcase
    end
    send_frame({4'($urandom), opc}, masked, form, LEN_W'(body_q.size()));
  endtask

  // Wait for the block to go quiet, then write both canvas registers
  task automatic set_canvas(input logic [CANVAS_W-1:0] w, input logic [CANVAS_W-1:0] h);
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_events != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CANVAS_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= CFG_CANVAS_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  initial begin
    int               p;
    int               phase_start;
    int               waited;
    logic [LEN_W-1:0] huge_len;

    in_chan.valid     = 1'b0;
    in_chan.data_byte = '0;

    w_plan = '{9'd100, 9'd256, 9'd1, 9'd511, 9'd0, 9'd0, 9'd0, 9'd256};
    h_plan = '{9'd100, 9'd256, 9'd1, 9'd0, 9'd300, 9'd0, 9'd0, 9'd1};
    for (p = 5; p <= 6; p++) begin
      w_plan[p] = 9'($urandom_range(1, 256));
      h_plan[p] = 9'($urandom_range(1, 256));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset canvas size
    body_q = '{8'h00, 8'h00, 8'hFF, 8'h5A};
    send_frame(FIN_BIT | 8'(OPC_BINARY), 1'b0, LEN_SHORT, 64'd4);
    body_q = '{8'hFF, 8'h00, 8'h07};
    send_frame(FIN_BIT | 8'(OPC_BINARY), 1'b0, LEN_EXT16, 64'd3);
    body_q.delete();
    send_frame(FIN_BIT | 8'(OPC_CLOSE), 1'b0, LEN_SHORT, 64'd0);
    body_q = '{8'h55};
    send_frame(FIN_BIT | 8'(OPC_CLOSE), 1'b0, LEN_EXT64, 64'd1);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) set_canvas(w_plan[p], h_plan[p]);
      phase_start = bytes_sent;
      if (p == NUM_PHASES - 1) begin
        gaps_on = 1'b0;
        // 16-bit length with a nonzero high byte
        body_q.delete();
        push_triplets(86);
        send_frame(FIN_BIT | 8'(OPC_BINARY), 1'b1, LEN_EXT16, LEN_W'(body_q.size()));
      end
      while (bytes_sent - phase_start < BYTES_PER_PHASE) random_frame();
    end

    // Finish on a frame whose 64-bit length has the top bit set; it never ends
    huge_len = {1'b1, 31'($urandom), 32'($urandom)};
    body_q.delete();
    push_triplets(30);
    send_frame(FIN_BIT | 8'(OPC_BINARY), 1'b1, LEN_EXT64, huge_len);
    in_chan.valid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_events != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    test_done <= 1'b1;
    @(posedge clk);

    $display("Sent %0d bytes in %0d frames over %0d canvas sizes, ending mid-frame.",
             bytes_sent, frames_sent, NUM_PHASES);
    $display("Compared %0d pixel updates and %0d close events.",
             pixels_checked, closes_checked);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ websocket_pixel_frame_parser_core.f @@
rtl/wpf_pkg.sv
rtl/wpf_if.sv
rtl/websocket_pixel_frame_parser_core.sv
dv/wpf_frame_checker.sv
dv/tb.sv
